// File: hdl/cldr_pkg.sv
`timescale 1ns / 1ps

package cldr_pkg;

  localparam int RowW   = 5;
  localparam int BitsW  = 32;
  localparam int CountW = 6;
  localparam int DataW  = 40;

  localparam logic [CountW-1:0] CountReset = 6'd32;

  localparam int StW = 3;
  localparam logic [StW-1:0] StIdle = 3'd0;
  localparam logic [StW-1:0] StRdRow = 3'd1;
  localparam logic [StW-1:0] StLdRow = 3'd2;
  localparam logic [StW-1:0] StRdK = 3'd3;
  localparam logic [StW-1:0] StAccK = 3'd4;
  localparam logic [StW-1:0] StEmit = 3'd5;

  // bits strictly above the diagonal of row r
  function automatic logic [BitsW-1:0] above_diag(input logic [RowW-1:0] r);
    logic [BitsW-1:0] m;
    begin
      if (r == 5'd31) begin
        m = '0;
      end else begin
        m = {BitsW{1'b1}} << (6'(r) + 6'd1);
      end
      return m;
    end
  endfunction

endpackage

// File: hdl/causal_link_matrix_reduction.sv
`timescale 1ns / 1ps

// channel   | dir | handshake                  | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata: row_index, future_bits; tlast: last_row
// m_axis    | out | m_axis_tvalid/m_axis_tready | tdata: out_row, link_bits; tlast: last_out
// cfg       | in  | cfg_valid_i/cfg_ready_o     | cfg_data_i: element_count
//
// While idle, rows load one per cycle into a row memory with a registered read port.
// A transaction with tlast starts the reduction: for each of the n link rows the
// single memory read port reads that row, then walks every row k, then the row is emitted.
// The block takes no input while reducing; a stalled output holds the sequencer.
// Reset clears control and sets element_count to 32; the row memory is not cleared.
module causal_link_matrix_reduction
  import cldr_pkg::*;
#(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,  // [4:0] row_index, [36:5] future_bits
  input  logic             s_axis_tlast,  // last_row
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,  // [4:0] out_row, [36:5] link_bits
  output logic             m_axis_tlast,  // last_out
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i    // element_count
);

  localparam int AddrW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int MaxN  = (MAX_ELEMENTS < 32) ? MAX_ELEMENTS : 32;

  logic [BitsW-1:0] mem [MAX_ELEMENTS];

  logic [StW-1:0]    state_q, state_d;
  logic [CountW-1:0] cnt_q;
  logic [RowW-1:0]   i_q, i_d;
  logic [RowW-1:0]   k_q, k_d;
  logic [BitsW-1:0]  row_q, row_d;
  logic [BitsW-1:0]  reach_q, reach_d;
  logic [BitsW-1:0]  rd_data_q;
  logic [AddrW-1:0]  rd_addr;
  logic              out_valid_q, out_valid_d;
  logic [RowW-1:0]   out_row_q;
  logic [BitsW-1:0]  out_bits_q;
  logic              out_last_q;
  logic              out_load;
  logic              in_acc;
  logic              wr_en;

  logic [RowW-1:0]   in_row;
  logic [BitsW-1:0]  in_bits;
  logic [CountW-1:0] n_one, n_act;
  logic [RowW-1:0]   n_last;
  logic [BitsW-1:0]  colmask;

  assign in_row  = s_axis_tdata[RowW-1:0];
  assign in_bits = s_axis_tdata[RowW+BitsW-1:RowW];

  assign n_one   = (cnt_q == '0) ? 6'd1 : cnt_q;
  assign n_act   = (n_one > 6'(MaxN)) ? 6'(MaxN) : n_one;
  assign n_last  = 5'(n_act - 6'd1);
  assign colmask = (n_act >= 6'd32) ? {BitsW{1'b1}} : ((32'd1 << n_act) - 32'd1);

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = in_acc && (32'(in_row) < MAX_ELEMENTS);
  assign out_load      = (state_q == StEmit) && (!out_valid_q || m_axis_tready);

  assign rd_addr = (state_q == StRdRow) ? AddrW'(i_q) : AddrW'(k_q);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    k_d         = k_q;
    row_d       = row_q;
    reach_d     = reach_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_acc && s_axis_tlast) begin
          i_d     = '0;
          state_d = StRdRow;
        end
      end
      StRdRow: begin
        state_d = StLdRow;
      end
      StLdRow: begin
        row_d   = rd_data_q & colmask;
        reach_d = '0;
        k_d     = '0;
        state_d = StRdK;
      end
      StRdK: begin
        state_d = StAccK;
      end
      StAccK: begin
        if (row_q[k_q]) begin
          reach_d = reach_q | (rd_data_q & colmask);
        end
        if (k_q == n_last) begin
          state_d = StEmit;
        end else begin
          k_d     = k_q + 5'd1;
          state_d = StRdK;
        end
      end
      StEmit: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (i_q == n_last) begin
            state_d = StIdle;
          end else begin
            i_d     = i_q + 5'd1;
            state_d = StRdRow;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= CountReset;
      i_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cnt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    reach_q <= reach_d;
    if (out_load) begin
      out_row_q  <= i_q;
      out_bits_q <= row_q & ~reach_q;
      out_last_q <= (i_q == n_last);
    end
  end

  // row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AddrW'(in_row)] <= in_bits & above_diag(in_row);
    end
    rd_data_q <= mem[rd_addr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(DataW-RowW-BitsW){1'b0}}, out_bits_q, out_row_q};
  assign m_axis_tlast  = out_last_q;

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("result not presented after load");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (out_row_q == n_last))
    else $error("last flag on wrong row");

  a_upper_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_bits_q & ~above_diag(out_row_q)) == '0))
    else $error("link bit at or below diagonal");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAccK) |-> (k_q <= n_last))
    else $error("scan index beyond element count");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (i_q <= n_last))
    else $error("row index beyond element count");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import cldr_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 80;
  localparam int LongStall     = 400;

  typedef struct {
    logic [RowW-1:0]  row;
    logic [BitsW-1:0] bits;
    logic             last;
  } link_row_t;

  class link_board;
    logic [BitsW-1:0]  causal_rows [32];
    logic [CountW-1:0] element_count;
    link_row_t         pending_links [$];
    int                mismatches;

    function new();
      element_count = CountReset;
      mismatches = 0;
    endfunction

    function int active();
      int n;
      n = int'(element_count);
      if (n == 0) n = 1;
      if (n > 32) n = 32;
      return n;
    endfunction

    // store the row; on the last row predict the whole link matrix
    function void note_row(logic [RowW-1:0] r, logic [BitsW-1:0] b, logic l);
      logic [BitsW-1:0] colmask;
      logic [BitsW-1:0] row;
      logic [BitsW-1:0] reach;
      link_row_t e;
      int n;
      causal_rows[r] = (r == 5'd31) ? '0 : (b & (32'hFFFF_FFFF << (int'(r) + 1)));
      if (!l) return;
      n = active();
      colmask = (n == 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 32'h1);
      for (int i = 0; i < n; i++) begin
        row = causal_rows[i] & colmask;
        reach = '0;
        for (int k = 0; k < n; k++) begin
          if (row[k]) reach |= causal_rows[k] & colmask;
        end
        e.row  = RowW'(i);
        e.bits = row & ~reach;
        e.last = (i == n - 1);
        pending_links.insert(pending_links.size(), e);
      end
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_link(logic [RowW-1:0] row, logic [BitsW-1:0] bits, logic last);
      link_row_t e;
      if (pending_links.size() == 0) begin
        report_mismatch($sformatf("unexpected link row %0d", row));
        return;
      end
      e = pending_links.pop_front();
      if (row !== e.row)
        report_mismatch($sformatf("out_row %0d, expected %0d", row, e.row));
      if (bits !== e.bits)
        report_mismatch($sformatf("row %0d link_bits %h, expected %h", e.row, bits, e.bits));
      if (last !== e.last)
        report_mismatch($sformatf("row %0d last_out %b, expected %b", e.row, last, e.last));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DataW-1:0]  s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DataW-1:0]  m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_data_i = '0;

  link_board sb;
  int snd_idle_pct = 31;
  int rcv_idle_pct = 67;
  int rows_sent = 0;
  int quiet_cycles = 0;
  int stall_asked = 0;
  int stall_served = 0;
  int stall_left = 0;

  causal_link_matrix_reduction #(
    .MAX_ELEMENTS(32)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // output side: random backpressure, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_asked != stall_served) begin
      stall_served = stall_asked;
      stall_left = LongStall;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_link(m_axis_tdata[RowW-1:0], m_axis_tdata[RowW+BitsW-1:RowW], m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_row(input logic [RowW-1:0] r, input logic [BitsW-1:0] b, input logic l);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(DataW-RowW-BitsW){1'b0}}, b, r};
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_row(r, b, l);
    rows_sent++;
  endtask

  // mostly rows inside the active set; sparse and chained patterns keep links alive
  task automatic send_frame(input int len, input logic closed);
    logic [RowW-1:0]  r;
    logic [BitsW-1:0] b;
    int n;
    n = sb.active();
    for (int j = 0; j < len; j++) begin
      r = ($urandom_range(9) < 7) ? RowW'($urandom_range(n - 1)) : RowW'($urandom);
      case ($urandom_range(2))
        0: b = $urandom;
        1: b = $urandom & $urandom & $urandom;
        default: b = 32'h3 << (int'(r) + 1);
      endcase
      send_row(r, b, closed && (j == len - 1));
    end
  endtask

  task automatic send_random(input int count);
    int stop;
    stop = rows_sent + count;
    while (rows_sent < stop) begin
      if ($urandom_range(9) < 8) begin
        send_frame($urandom_range(1, 6), 1'b1);
      end else begin
        send_frame($urandom_range(1, 4), 1'b0);
      end
    end
    send_frame(1, 1'b1);
  endtask

  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_links.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CountW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.element_count = v;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every row written once, so no reduction reads an unwritten row
    for (int i = 0; i < 32; i++) send_row(RowW'(i), $urandom, 1'b0);

    // full rows, empty rows, top rows, a short chain
    send_row(5'd0, 32'hFFFF_FFFF, 1'b0);
    send_row(5'd1, 32'h0000_0000, 1'b0);
    send_row(5'd31, 32'hFFFF_FFFF, 1'b0);
    send_row(5'd30, 32'h8000_0000, 1'b0);
    send_row(5'd3, 32'h0000_0030, 1'b0);
    send_row(5'd4, 32'h0000_0020, 1'b0);
    send_row(5'd2, 32'h0000_0000, 1'b1);
    settle_block();
    write_count(6'd1);
    send_row(5'd0, 32'hFFFF_FFFF, 1'b1);
    settle_block();
    write_count(6'd0);
    send_row(5'd7, $urandom, 1'b1);
    settle_block();
    write_count(6'd63);
    send_row(5'd31, 32'h0000_0000, 1'b1);
    settle_block();

    write_count(CountW'($urandom_range(2, 8)));
    stall_asked++;
    send_random(18);
    settle_block();

    snd_idle_pct = 67;
    rcv_idle_pct = 31;
    write_count(CountW'($urandom_range(9, 20)));
    send_random(8);
    settle_block();
    send_random(8);
    settle_block();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_count(6'd32);
    send_random(18);
    settle_block();

    if (sb.mismatches == 0 && sb.pending_links.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: causal_link_matrix_reduction.f
hdl/cldr_pkg.sv
hdl/causal_link_matrix_reduction.sv
test/tb.sv
